/* rtl/core/bba_pkg.sv */
// Shared constants and types for the bitmap block allocator.
`default_nettype none
package bba_pkg;

    // Heap geometry.
    localparam int NUM_BLOCKS   = 65536;
    localparam int BLOCK_BYTES  = 16;
    localparam int HEADER_BYTES = 8;
    localparam int WORD_BITS    = 64;
    localparam int BIT_W        = $clog2(WORD_BITS);
    localparam int MAP_WORDS    = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_W       = $clog2(MAP_WORDS);
    localparam int BLOCK_SHIFT  = $clog2(BLOCK_BYTES);
    localparam int HEAP_BYTES   = NUM_BLOCKS * BLOCK_BYTES;

    // Field widths.
    localparam int SIZE_W = 21;
    localparam int PTR_W  = 21;
    localparam int ADDR_W = 20;

    // Internal widths: block positions carry one extra bit to reach the heap end.
    localparam int POS_W  = $clog2(NUM_BLOCKS) + 1;
    localparam int IDX_W  = POS_W - 1;
    localparam int SUM_W  = SIZE_W + 1;
    localparam int LEFT_W = SUM_W - BLOCK_SHIFT;
    localparam int END_W  = LEFT_W + 1;
    localparam int TAKE_W = BIT_W + 1;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_ZERO    = 2'd1,
        STATUS_NOSPACE = 2'd2,
        STATUS_RANGE   = 2'd3
    } status_t;

    // Result of one step of the run unit over one bitmap word.
    typedef struct packed {
        logic [WORD_BITS-1:0] mask;
        logic                 conflict;
        logic [WORD_BITS-1:0] new_word;
        logic [POS_W-1:0]     pos_next;
        logic [LEFT_W-1:0]    left_next;
        logic                 last;
    } step_t;

endpackage
`default_nettype wire

/* rtl/core/bitmap_block_allocator_top.sv */
// Top level of the bitmap block allocator: request sequencer, bitmap memory and run unit.
// One request is in work at a time, walking the bitmap memory one word per read.
// After reset a clearing pass zeroes the 1024 bitmap words, during which requests
// are stalled.
`default_nettype none
module bitmap_block_allocator_top
    import bba_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_stall,
    input  wire logic              opcode,
    input  wire logic [SIZE_W-1:0] size_bytes,
    input  wire logic [PTR_W-1:0]  pointer_offset,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output logic [1:0]             status,
    output logic [ADDR_W-1:0]      address_offset
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_TEST_RD,
        S_TEST_CHK,
        S_MOD_RD,
        S_MOD_WR,
        S_RESP
    } state_t;

    localparam logic [WORD_W-1:0] LAST_WORD = WORD_W'(MAP_WORDS - 1);

    state_t              state_reg,       state_next;
    logic [WORD_W-1:0]   word_reg,        word_next;
    logic [POS_W-1:0]    pos_reg,         pos_next;
    logic [LEFT_W-1:0]   left_reg,        left_next;
    logic [IDX_W-1:0]    start_reg,       start_next;
    logic [LEFT_W-1:0]   blocks_reg,      blocks_next;
    logic                free_reg,        free_next;
    status_t             result_reg,      result_next;
    logic                rsp_valid_reg,   rsp_valid_next;
    logic [1:0]          rsp_status_reg,  rsp_status_next;
    logic [ADDR_W-1:0]   rsp_addr_reg,    rsp_addr_next;

    logic                 mem_wr_en;
    logic [WORD_W-1:0]    mem_wr_addr;
    logic [WORD_BITS-1:0] mem_wr_data;
    logic                 mem_rd_en;
    logic [WORD_W-1:0]    mem_rd_addr;
    logic [WORD_BITS-1:0] mem_rd_data;
    step_t                step;

    logic [SUM_W-1:0]     req_sum;
    logic [LEFT_W-1:0]    req_blocks;
    logic [PTR_W-1:0]     free_base;
    logic [IDX_W-1:0]     free_idx;
    logic [END_W-1:0]     free_end;
    logic                 free_bad;
    logic [BIT_W-1:0]     low_free;
    logic [IDX_W-1:0]     cand_start;
    logic [END_W-1:0]     cand_end;
    logic                 word_full;
    logic [ADDR_W-1:0]    grant_addr;

    // Index of the lowest clear bit of a word; all ones gives the top index.
    function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_BITS-1:0] w);
        logic [BIT_W-1:0] n;
        n = BIT_W'(WORD_BITS - 1);
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!w[i])
            begin
                n = BIT_W'(i);
            end
        end
        return n;
    endfunction

    bba_map_mem u_map_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    bba_run_unit u_run_unit (
        .pos      (pos_reg),
        .left     (left_reg),
        .word     (mem_rd_data),
        .set_mode (!free_reg),
        .step     (step)
    );

    // Block count of the request, including the header, rounded up.
    always_comb
    begin
        req_sum    = SUM_W'(size_bytes) + SUM_W'(HEADER_BYTES + BLOCK_BYTES - 1);
        req_blocks = req_sum[SUM_W-1:BLOCK_SHIFT];
    end

    // Range checks of a free request.
    always_comb
    begin
        free_base = pointer_offset - PTR_W'(HEADER_BYTES);
        free_idx  = free_base[BLOCK_SHIFT +: IDX_W];
        free_end  = END_W'(free_idx) + END_W'(req_blocks);
        free_bad  = (pointer_offset < PTR_W'(HEADER_BYTES))
                 || (free_base >= PTR_W'(HEAP_BYTES))
                 || (free_end > END_W'(NUM_BLOCKS));
    end

    // Candidate run of the word just read.
    always_comb
    begin
        low_free   = lowest_zero(mem_rd_data);
        cand_start = {word_reg, low_free};
        cand_end   = END_W'(cand_start) + END_W'(blocks_reg);
        word_full  = &mem_rd_data;
        grant_addr = ADDR_W'({start_reg, {BLOCK_SHIFT{1'b0}}}) + ADDR_W'(HEADER_BYTES);
    end

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        word_next       = word_reg;
        pos_next        = pos_reg;
        left_next       = left_reg;
        start_next      = start_reg;
        blocks_next     = blocks_reg;
        free_next       = free_reg;
        result_next     = result_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_status_next = rsp_status_reg;
        rsp_addr_next   = rsp_addr_reg;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = word_reg;
        mem_wr_data     = '0;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = word_reg;
        req_stall       = (state_reg != S_IDLE);

        // The response register empties when its transaction completes.
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = word_reg;
                if (word_reg == LAST_WORD)
                begin
                    word_next  = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    word_next = word_reg + WORD_W'(1);
                end
            end

            S_IDLE:
            begin
                if (req_valid)
                begin
                    blocks_next = req_blocks;
                    free_next   = opcode;
                    if (size_bytes == '0)
                    begin
                        result_next = STATUS_ZERO;
                        state_next  = S_RESP;
                    end
                    else if (!opcode)
                    begin
                        word_next  = '0;
                        state_next = S_SCAN_RD;
                    end
                    else if (free_bad)
                    begin
                        result_next = STATUS_RANGE;
                        state_next  = S_RESP;
                    end
                    else
                    begin
                        pos_next   = {1'b0, free_idx};
                        left_next  = req_blocks;
                        state_next = S_MOD_RD;
                    end
                end
            end

            S_SCAN_RD:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = word_reg;
                state_next  = S_SCAN_CHK;
            end

            S_SCAN_CHK:
            begin
                if (word_full || (cand_end > END_W'(NUM_BLOCKS)))
                begin
                    if (word_reg == LAST_WORD)
                    begin
                        result_next = STATUS_NOSPACE;
                        state_next  = S_RESP;
                    end
                    else
                    begin
                        word_next  = word_reg + WORD_W'(1);
                        state_next = S_SCAN_RD;
                    end
                end
                else
                begin
                    start_next = cand_start;
                    pos_next   = {1'b0, cand_start};
                    left_next  = blocks_reg;
                    state_next = S_TEST_RD;
                end
            end

            S_TEST_RD:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = pos_reg[POS_W-2:BIT_W];
                state_next  = S_TEST_CHK;
            end

            S_TEST_CHK:
            begin
                if (step.conflict)
                begin
                    if (word_reg == LAST_WORD)
                    begin
                        result_next = STATUS_NOSPACE;
                        state_next  = S_RESP;
                    end
                    else
                    begin
                        word_next  = word_reg + WORD_W'(1);
                        state_next = S_SCAN_RD;
                    end
                end
                else if (step.last)
                begin
                    // Run is free: go back to its start and mark it used.
                    pos_next   = {1'b0, start_reg};
                    left_next  = blocks_reg;
                    state_next = S_MOD_RD;
                end
                else
                begin
                    pos_next   = step.pos_next;
                    left_next  = step.left_next;
                    state_next = S_TEST_RD;
                end
            end

            S_MOD_RD:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = pos_reg[POS_W-2:BIT_W];
                state_next  = S_MOD_WR;
            end

            S_MOD_WR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = pos_reg[POS_W-2:BIT_W];
                mem_wr_data = step.new_word;
                if (step.last)
                begin
                    result_next = STATUS_OK;
                    state_next  = S_RESP;
                end
                else
                begin
                    pos_next   = step.pos_next;
                    left_next  = step.left_next;
                    state_next = S_MOD_RD;
                end
            end

            S_RESP:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = result_reg;
                    if ((result_reg == STATUS_OK) && !free_reg)
                    begin
                        rsp_addr_next = grant_addr;
                    end
                    else
                    begin
                        rsp_addr_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            word_reg       <= '0;
            pos_reg        <= '0;
            left_reg       <= '0;
            start_reg      <= '0;
            blocks_reg     <= '0;
            free_reg       <= 1'b0;
            result_reg     <= STATUS_OK;
            rsp_valid_reg  <= 1'b0;
            rsp_status_reg <= '0;
            rsp_addr_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            word_reg       <= word_next;
            pos_reg        <= pos_next;
            left_reg       <= left_next;
            start_reg      <= start_next;
            blocks_reg     <= blocks_next;
            free_reg       <= free_next;
            result_reg     <= result_next;
            rsp_valid_reg  <= rsp_valid_next;
            rsp_status_reg <= rsp_status_next;
            rsp_addr_reg   <= rsp_addr_next;
        end
    end

    assign rsp_valid      = rsp_valid_reg;
    assign status         = rsp_status_reg;
    assign address_offset = rsp_addr_reg;

endmodule
`default_nettype wire

/* rtl/core/bba_map_mem.sv */
// Bitmap word memory with one write port and one registered read port.
`default_nettype none
module bba_map_mem
    import bba_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 wr_en,
    input  wire logic [WORD_W-1:0]    wr_addr,
    input  wire logic [WORD_BITS-1:0] wr_data,
    input  wire logic                 rd_en,
    input  wire logic [WORD_W-1:0]    rd_addr,
    output logic      [WORD_BITS-1:0] rd_data
);

    logic [WORD_BITS-1:0] mem [MAP_WORDS];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

/* rtl/core/bba_run_unit.sv */
// Shared run unit: builds the mask of one word slice of a run, tests and updates it.
`default_nettype none
module bba_run_unit
    import bba_pkg::*;
(
    input  wire logic [POS_W-1:0]     pos,
    input  wire logic [LEFT_W-1:0]    left,
    input  wire logic [WORD_BITS-1:0] word,
    input  wire logic                 set_mode,
    output step_t                     step
);

    localparam logic [WORD_BITS-1:0] ONES = '1;

    logic [BIT_W-1:0]  bit_pos;
    logic [TAKE_W-1:0] avail;
    logic [TAKE_W-1:0] take;
    logic [TAKE_W-1:0] end_bit;
    logic [WORD_BITS-1:0] lo_mask;
    logic [WORD_BITS-1:0] hi_mask;

    // Slice of the run that falls into the current word.
    always_comb
    begin
        bit_pos = pos[BIT_W-1:0];
        avail   = TAKE_W'(WORD_BITS) - {1'b0, bit_pos};
        if (left < LEFT_W'(avail))
        begin
            take = left[TAKE_W-1:0];
        end
        else
        begin
            take = avail;
        end
        end_bit = {1'b0, bit_pos} + take;
    end

    // Mask from the first bit up to, but not including, the end bit.
    always_comb
    begin
        lo_mask = ONES << bit_pos;
        if (end_bit[TAKE_W-1])
        begin
            hi_mask = ONES;
        end
        else
        begin
            hi_mask = ~(ONES << end_bit[BIT_W-1:0]);
        end
    end

    // Test, update and advance.
    always_comb
    begin
        step.mask      = lo_mask & hi_mask;
        step.conflict  = |(word & step.mask);
        step.new_word  = set_mode ? (word | step.mask) : (word & ~step.mask);
        step.pos_next  = pos + POS_W'(take);
        step.left_next = left - LEFT_W'(take);
        step.last      = (left == LEFT_W'(take));
    end

endmodule
`default_nettype wire

/* sim/tb_bitmap_block_allocator_top.sv */
// Self-checking testbench for the bitmap block allocator top level.
`timescale 1ns / 100ps
module tb_bitmap_block_allocator_top;
    import bba_pkg::*;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 11;
    localparam int RANDOM_ITEMS  = 500;
    localparam int PHASE_ITEMS   = 125;
    localparam int BATCH_ITEMS   = 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 64;
    localparam int MAX_LIVE      = 120;
    // A slow allocate re-tests a long free stretch from many words; allow it several times over.
    localparam int IDLE_LIMIT    = 1500000;

    typedef enum {SPAN_TEST, SPAN_SET, SPAN_CLEAR} span_op_t;

    typedef struct {
        logic              op;
        logic [SIZE_W-1:0] size;
        logic [PTR_W-1:0]  ptr;
    } heap_req_t;

    typedef struct {
        status_t           status;
        logic [ADDR_W-1:0] addr;
    } grant_t;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
    } region_t;

    // Block ports; the driven inputs are known from time zero.
    logic              clk            = 1'b0;
    logic              rst_n          = 1'b0;
    logic              req_valid      = 1'b0;
    logic              req_stall;
    logic              opcode         = OP_ALLOC;
    logic [SIZE_W-1:0] size_bytes     = '0;
    logic [PTR_W-1:0]  pointer_offset = '0;
    logic              rsp_valid;
    logic              rsp_stall      = 1'b0;
    logic [1:0]        status;
    logic [ADDR_W-1:0] address_offset;

    // Shadow of the used-block bitmap and the queues around it.
    logic [WORD_BITS-1:0] used_map [MAP_WORDS];
    heap_req_t            pending_reqs[$];
    grant_t               expected_grants[$];
    region_t              live_regions[$];

    int unsigned send_idle_pct = 0;
    int unsigned rsp_stall_pct = 0;
    bit          req_done      = 1'b0;
    bit          hold_request  = 1'b0;
    bit          hold_done     = 1'b0;
    int unsigned hold_left     = 0;
    int unsigned quiet_cycles  = 0;
    int          error_count   = 0;

    bitmap_block_allocator_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .opcode         (opcode),
        .size_bytes     (size_bytes),
        .pointer_offset (pointer_offset),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .status         (status),
        .address_offset (address_offset)
    );

    always #CLK_HALF clk = ~clk;

    // Tests, sets or clears a run of blocks in the shadow bitmap, one word at a time.
    function automatic bit span_walk(int unsigned first, int unsigned count, span_op_t what);
        int unsigned          at;
        int unsigned          left;
        int unsigned          take;
        int unsigned          word_idx;
        logic [WORD_BITS-1:0] mask;
        at   = first;
        left = count;
        while (left > 0)
        begin
            take = WORD_BITS - at % WORD_BITS;
            if (take > left)
                take = left;
            if (take == WORD_BITS)
                mask = '1;
            else
                mask = ((64'd1 << take) - 64'd1) << (at % WORD_BITS);
            word_idx = at / WORD_BITS;
            if (word_idx >= MAP_WORDS)
                return 1'b0;
            case (what)
                SPAN_TEST:
                    if ((used_map[word_idx] & mask) != '0)
                        return 1'b0;
                SPAN_SET:
                    used_map[word_idx] |= mask;
                default:
                    used_map[word_idx] &= ~mask;
            endcase
            at   += take;
            left -= take;
        end
        return 1'b1;
    endfunction

    // First-fit placement, run release or rejection for one accepted request; queues its grant.
    task automatic predict_grant(heap_req_t r);
        int unsigned blocks;
        int unsigned start;
        int unsigned lowest;
        int unsigned base;
        int          w;
        grant_t      g;
        region_t     held;
        blocks   = (32'(r.size) + HEADER_BYTES + BLOCK_BYTES - 1) / BLOCK_BYTES;
        g.status = STATUS_NOSPACE;
        g.addr   = '0;
        if (r.size == '0)
            g.status = STATUS_ZERO;
        else if (r.op == OP_ALLOC)
        begin
            for (w = 0; w < MAP_WORDS; w++)
            begin
                if (used_map[w] == '1)
                    continue;
                lowest = 0;
                while (lowest < WORD_BITS - 1 && used_map[w][lowest])
                    lowest++;
                start = w * WORD_BITS + lowest;
                if (start + blocks > NUM_BLOCKS)
                    continue;
                if (span_walk(start, blocks, SPAN_TEST))
                begin
                    void'(span_walk(start, blocks, SPAN_SET));
                    g.status  = STATUS_OK;
                    g.addr    = ADDR_W'(start * BLOCK_BYTES + HEADER_BYTES);
                    held.addr = g.addr;
                    held.size = r.size;
                    live_regions.push_back(held);
                    break;
                end
            end
        end
        else if (r.ptr < HEADER_BYTES)
            g.status = STATUS_RANGE;
        else
        begin
            base = 32'(r.ptr) - HEADER_BYTES;
            if (base >= HEAP_BYTES || base / BLOCK_BYTES + blocks > NUM_BLOCKS)
                g.status = STATUS_RANGE;
            else
            begin
                void'(span_walk(base / BLOCK_BYTES, blocks, SPAN_CLEAR));
                g.status = STATUS_OK;
            end
        end
        expected_grants.push_back(g);
    endtask

    task automatic report_mismatch(string what);
        $display("MISMATCH at %0t ns: %s", $realtime, what);
        error_count++;
    endtask

    task automatic push_req(logic op, int unsigned size, int unsigned ptr);
        heap_req_t r;
        r.op   = op;
        r.size = SIZE_W'(size);
        r.ptr  = PTR_W'(ptr);
        pending_reqs.push_back(r);
    endtask

    // Returns once every queued request transaction has been accepted.
    task automatic wait_sent();
        while (pending_reqs.size() != 0 || req_valid)
            @(posedge clk);
    endtask

    // Request driver: holds a stalled transaction, otherwise offers the next one or idles.
    always @(negedge clk)
    begin
        heap_req_t next_req;
        if (rst_n && (!req_valid || req_done))
        begin
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                next_req = pending_reqs.pop_front();
                opcode         <= next_req.op;
                size_bytes     <= next_req.size;
                pointer_offset <= next_req.ptr;
                req_valid      <= 1'b1;
            end
            else
                req_valid <= 1'b0;
        end
    end

    // Response stall: random, or forced high during the long hold-off.
    always @(negedge clk)
        rsp_stall <= (hold_left != 0) || ($urandom_range(0, 99) < rsp_stall_pct);

    // Hold-off counter, started once on request.
    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_request && !hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Monitor: predicts on each accepted request and checks each accepted result.
    always @(posedge clk)
    begin
        heap_req_t taken;
        grant_t    want;
        req_done <= rst_n && req_valid && !req_stall;
        if (rst_n && req_valid && !req_stall)
        begin
            taken.op   = opcode;
            taken.size = size_bytes;
            taken.ptr  = pointer_offset;
            predict_grant(taken);
        end
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_grants.size() == 0)
                report_mismatch($sformatf("result with none pending: status %0d address %0h",
                                          status, address_offset));
            else
            begin
                want = expected_grants.pop_front();
                if (status !== want.status)
                    report_mismatch($sformatf("status %0d, predicted %s",
                                              status, want.status.name()));
                if (address_offset !== want.addr)
                    report_mismatch($sformatf("address %0h, predicted %0h",
                                              address_offset, want.addr));
            end
        end
    end

    // Watchdog: ends the run when no transaction moves for too long.
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("bitmap_block_allocator_top regression: fail");
            $finish;
        end
    end

    // Stimulus: directed corners, then phased random traffic.
    initial
    begin
        int unsigned pick;
        int unsigned victim_idx;
        region_t     victim;
        int          n;
        foreach (used_map[i])
            used_map[i] = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Zero size on both operations, small allocates and reuse after a free.
        push_req(OP_ALLOC, 0, 0);
        push_req(OP_FREE, 0, HEADER_BYTES);
        push_req(OP_ALLOC, 1, 0);
        push_req(OP_ALLOC, 8, 21'h1FFFFF);
        push_req(OP_ALLOC, 9, 0);
        push_req(OP_FREE, 8, 24);
        push_req(OP_ALLOC, 8, 0);
        // Frees below the header, past the heap, and running over its end.
        push_req(OP_FREE, 1, 0);
        push_req(OP_FREE, 1, HEADER_BYTES - 1);
        push_req(OP_FREE, 1, HEAP_BYTES + HEADER_BYTES);
        push_req(OP_FREE, 1, 21'h1FFFFF);
        push_req(OP_FREE, 8, HEAP_BYTES - BLOCK_BYTES + HEADER_BYTES);
        push_req(OP_FREE, 9, HEAP_BYTES - BLOCK_BYTES + HEADER_BYTES);
        // Requests larger than the heap.
        push_req(OP_ALLOC, 21'h1FFFFF, 0);
        push_req(OP_ALLOC, HEAP_BYTES, 0);
        // Whole heap in one run, then a full heap, then freeing free blocks.
        push_req(OP_FREE, HEAP_BYTES - HEADER_BYTES, HEADER_BYTES);
        push_req(OP_ALLOC, HEAP_BYTES - HEADER_BYTES, 21'h0AAAAA);
        push_req(OP_ALLOC, 1, 0);
        push_req(OP_FREE, HEAP_BYTES - HEADER_BYTES, HEADER_BYTES);
        push_req(OP_FREE, 100, HEADER_BYTES);
        // A full first word, then a candidate at its lowest free bit that collides.
        push_req(OP_ALLOC, WORD_BITS * BLOCK_BYTES - HEADER_BYTES, 0);
        push_req(OP_ALLOC, 1, 0);
        push_req(OP_FREE, 1, HEADER_BYTES);
        push_req(OP_ALLOC, 24, 0);
        push_req(OP_FREE, HEAP_BYTES - HEADER_BYTES, HEADER_BYTES);
        wait_sent();
        live_regions.delete();

        // Random part: mostly matched allocate and free pairs, plus corner noise.
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % PHASE_ITEMS == 0)
            begin
                case (n / PHASE_ITEMS)
                    0:       begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
                    1:       begin send_idle_pct = 62; rsp_stall_pct = 0;  end
                    2:       begin send_idle_pct = 0;  rsp_stall_pct = 62; end
                    default: begin send_idle_pct = 22; rsp_stall_pct = 22; end
                endcase
            end
            // Long response hold-off while requests keep coming.
            if (n == PHASE_ITEMS / 2)
                hold_request = 1'b1;
            pick = $urandom_range(0, 99);
            if (live_regions.size() > MAX_LIVE)
                pick = 0;
            if (pick < 35 && live_regions.size() != 0)
            begin
                victim_idx = $urandom_range(0, live_regions.size() - 1);
                victim     = live_regions[victim_idx];
                live_regions.delete(victim_idx);
                push_req(OP_FREE, victim.size, victim.addr);
            end
            else if (pick < 75)
            begin
                if ($urandom_range(0, 3) == 0)
                    push_req(OP_ALLOC, $urandom_range(1, 4096), $urandom_range(0, 2097151));
                else
                    push_req(OP_ALLOC, $urandom_range(1, 256), $urandom_range(0, 2097151));
            end
            else if (pick < 82)
                push_req(OP_ALLOC, $urandom_range(65536, 131072), $urandom_range(0, 2097151));
            else if (pick < 87)
                push_req(OP_ALLOC, $urandom_range(HEAP_BYTES - HEADER_BYTES + 1, 2097151),
                         $urandom_range(0, 2097151));
            else if (pick < 92)
                push_req(1'($urandom_range(0, 1)), 0, $urandom_range(0, 2097151));
            else if ($urandom_range(0, 1) == 0)
                push_req(OP_FREE, $urandom_range(1, 4096), $urandom_range(0, 2097151));
            else
                push_req(OP_FREE, $urandom_range(0, 2097151), $urandom_range(0, 2097151));
            if (n % BATCH_ITEMS == BATCH_ITEMS - 1)
                wait_sent();
        end
        wait_sent();

        // Drain: every grant in, then a quiet tail.
        while (expected_grants.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("bitmap_block_allocator_top regression: pass");
        else
            $display("bitmap_block_allocator_top regression: fail");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/bba_pkg.sv
rtl/core/bba_map_mem.sv
rtl/core/bba_run_unit.sv
rtl/core/bitmap_block_allocator_top.sv
sim/tb_bitmap_block_allocator_top.sv
